// ----- rtl/mi3_pkg.sv -----
// ----------------------------------------------------------------------------
// mi3_pkg
// Types, widths and index tables shared by the 3x3 matrix inverse pipeline.
// ----------------------------------------------------------------------------
package mi3_pkg;

  localparam int NumElem = 9;
  localparam int InW     = 16;  // Q4.12 element
  localparam int OutW    = 32;  // Q16.16 result
  localparam int PrdW    = 32;  // element * element
  localparam int CofW    = 33;  // cofactor, Q9.24
  localparam int DpW     = 49;  // element * cofactor
  localparam int DetW    = 50;  // determinant, Q14.36
  localparam int CmW     = 32;  // |cofactor|
  localparam int DmW     = 49;  // |determinant|
  localparam int EW      = DmW + 1;  // divisor 2*|det|
  localparam int FracSh  = 29;  // 2 * 2^28
  localparam int NW      = CmW + FracSh + 1;  // dividend 2*|cof|*2^28 + |det|
  localparam int QW      = 33;  // quotient bits resolved by the divider
  localparam int HiW     = NW - QW;

  // Cofactor k = el[La]*el[Lb] - el[Ra]*el[Rb]
  localparam int CofLa [NumElem] = '{8, 2, 5, 5, 8, 2, 7, 1, 4};
  localparam int CofLb [NumElem] = '{4, 7, 1, 6, 0, 3, 3, 6, 0};
  localparam int CofRa [NumElem] = '{5, 8, 2, 8, 2, 5, 4, 7, 1};
  localparam int CofRb [NumElem] = '{7, 1, 4, 3, 6, 0, 6, 0, 3};
  // Determinant expands along the first column: el[k] * cof[DetCof[k]]
  localparam int DetCof [3] = '{0, 3, 6};

  typedef struct packed {
    logic signed [InW-1:0] in_e0;
    logic signed [InW-1:0] in_e1;
    logic signed [InW-1:0] in_e2;
    logic signed [InW-1:0] in_e3;
    logic signed [InW-1:0] in_e4;
    logic signed [InW-1:0] in_e5;
    logic signed [InW-1:0] in_e6;
    logic signed [InW-1:0] in_e7;
    logic signed [InW-1:0] in_e8;
  } mi3_in_t;

  typedef struct packed {
    logic signed [OutW-1:0] out_e0;
    logic signed [OutW-1:0] out_e1;
    logic signed [OutW-1:0] out_e2;
    logic signed [OutW-1:0] out_e3;
    logic signed [OutW-1:0] out_e4;
    logic signed [OutW-1:0] out_e5;
    logic signed [OutW-1:0] out_e6;
    logic signed [OutW-1:0] out_e7;
    logic signed [OutW-1:0] out_e8;
    logic                   singular;
    logic                   saturated;
  } mi3_out_t;

  // One division lane
  typedef struct packed {
    logic [EW-1:0] rem;
    logic [QW-1:0] low;   // dividend bits still to shift in
    logic [QW-1:0] quo;
    logic          neg;
    logic          ovf;
  } mi3_lane_t;

  // One divider stage: shared divisor and nine lanes
  typedef struct packed {
    logic                           sing;
    logic [EW-1:0]                  den;
    mi3_lane_t [NumElem-1:0]        lane;
  } mi3_div_t;

endpackage

// ----- rtl/matrix3_inverse_unit.sv -----
// ----------------------------------------------------------------------------
// matrix3_inverse_unit
// 3x3 matrix inverse by the adjugate: Q4.12 in, saturated Q16.16 out.
//
//   channel | handshake               | payload
//   --------+-------------------------+-----------------------
//   in      | in_valid_i / in_ready_o | in_data_i  (mi3_in_t)
//   out     | out_valid_o/out_ready_i | out_data_o (mi3_out_t)
//
// One request per cycle while the output is not stalled; the path runs through six stages of products,
// cofactors and determinant, 33 divider stages of one quotient bit each,
// and the output register.
// Reset clears only the valid bits.
// A stalled output freezes the whole pipeline; nothing is dropped.
// ----------------------------------------------------------------------------
module matrix3_inverse_unit import mi3_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  mi3_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output mi3_out_t out_data_o
);

  logic     en;
  logic     fr_valid, dv_valid;
  mi3_div_t fr_data, dv_data;
  logic     out_valid_q;
  mi3_out_t out_d, out_q;

  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en;

  mi3_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .data_i  (in_data_i),
    .valid_o (fr_valid),
    .data_o  (fr_data)
  );

  mi3_divider u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (fr_valid),
    .data_i  (fr_data),
    .valid_o (dv_valid),
    .data_o  (dv_data)
  );

  // Sign, saturation and singular handling
  always_comb begin
    logic [OutW-1:0] res [NumElem];
    logic [QW-1:0]   q;
    logic [QW-1:0]   qneg;
    logic            clip;
    clip = 1'b0;
    for (int k = 0; k < NumElem; k++) begin
      q    = dv_data.lane[k].quo;
      qneg = -q;
      if (dv_data.sing) begin
        res[k] = '0;
      end else if (dv_data.lane[k].neg && (q != '0)) begin
        if (dv_data.lane[k].ovf || (q > {2'b01, {(QW-2){1'b0}}})) begin
          res[k] = {1'b1, {(OutW-1){1'b0}}};
          clip   = 1'b1;
        end else begin
          res[k] = qneg[OutW-1:0];
        end
      end else begin
        if (dv_data.lane[k].ovf || (q > {2'b00, {(QW-2){1'b1}}})) begin
          res[k] = {1'b0, {(OutW-1){1'b1}}};
          clip   = 1'b1;
        end else begin
          res[k] = q[OutW-1:0];
        end
      end
    end
    out_d.out_e0    = res[0];
    out_d.out_e1    = res[1];
    out_d.out_e2    = res[2];
    out_d.out_e3    = res[3];
    out_d.out_e4    = res[4];
    out_d.out_e5    = res[5];
    out_d.out_e6    = res[6];
    out_d.out_e7    = res[7];
    out_d.out_e8    = res[8];
    out_d.singular  = dv_data.sing;
    out_d.saturated = clip;
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= dv_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // A singular result carries all-zero words and no saturation
  a_singular_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.singular |->
      !out_data_o.saturated && out_data_o.out_e0 == '0 && out_data_o.out_e4 == '0 &&
      out_data_o.out_e8 == '0)
    else $error("singular result not cleared");

  // A stalled pipeline holds its last divider stage
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |=> $stable(dv_valid))
    else $error("divider moved during stall");

  // A result only appears from a valid divider output
  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(dv_valid))
    else $error("result without divider output");

endmodule

// ----- rtl/mi3_front.sv -----
// ----------------------------------------------------------------------------
// mi3_front
// Cofactors, determinant and divider setup in six register stages.
// ----------------------------------------------------------------------------
module mi3_front import mi3_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     en_i,
  input  logic     valid_i,
  input  mi3_in_t  data_i,
  output logic     valid_o,
  output mi3_div_t data_o
);

  logic [5:0] v_q;
  logic signed [InW-1:0]  el_in [NumElem];
  logic signed [InW-1:0]  el1_q [NumElem];
  logic signed [InW-1:0]  n2_q [3], n3_q [3];
  logic signed [PrdW-1:0] pl_d [NumElem], pl_q [NumElem];
  logic signed [PrdW-1:0] pr_d [NumElem], pr_q [NumElem];
  logic signed [CofW-1:0] cof_d [NumElem], cof3_q [NumElem];
  logic signed [CofW-1:0] cof4_q [NumElem], cof5_q [NumElem];
  logic signed [DpW-1:0]  dp_d [3], dp_q [3];
  logic signed [DetW-1:0] det_d, det_q;
  mi3_div_t               set_d, set_q;

  assign el_in[0] = data_i.in_e0;
  assign el_in[1] = data_i.in_e1;
  assign el_in[2] = data_i.in_e2;
  assign el_in[3] = data_i.in_e3;
  assign el_in[4] = data_i.in_e4;
  assign el_in[5] = data_i.in_e5;
  assign el_in[6] = data_i.in_e6;
  assign el_in[7] = data_i.in_e7;
  assign el_in[8] = data_i.in_e8;

  // Products, cofactor differences, determinant terms and determinant sum
  always_comb begin
    for (int k = 0; k < NumElem; k++) begin
      pl_d[k]  = el1_q[CofLa[k]] * el1_q[CofLb[k]];
      pr_d[k]  = el1_q[CofRa[k]] * el1_q[CofRb[k]];
      cof_d[k] = pl_q[k] - pr_q[k];
    end
    for (int i = 0; i < 3; i++) begin
      dp_d[i] = n3_q[i] * cof3_q[DetCof[i]];
    end
    det_d = dp_q[0] + dp_q[1] + dp_q[2];
  end

  // Divider setup: magnitudes, dividend, divisor, signs, singular flag, early overflow
  always_comb begin
    logic [DetW-1:0] dneg;
    logic [DmW-1:0]  dm;
    logic [CofW-1:0] cneg;
    logic [CmW-1:0]  cm;
    logic [NW-1:0]   num;
    dneg = -det_q;
    dm   = det_q[DetW-1] ? dneg[DmW-1:0] : det_q[DmW-1:0];
    set_d.sing = (det_q == '0);
    set_d.den  = {dm, 1'b0};
    for (int k = 0; k < NumElem; k++) begin
      cneg = -cof5_q[k];
      cm   = cof5_q[k][CofW-1] ? cneg[CmW-1:0] : cof5_q[k][CmW-1:0];
      num  = {1'b0, cm, {FracSh{1'b0}}} + {{(NW-DmW){1'b0}}, dm};
      set_d.lane[k].rem = {{(EW-HiW){1'b0}}, num[NW-1:QW]};
      set_d.lane[k].low = num[QW-1:0];
      set_d.lane[k].quo = '0;
      set_d.lane[k].neg = cof5_q[k][CofW-1] ^ det_q[DetW-1];
      set_d.lane[k].ovf = ({{(EW-HiW){1'b0}}, num[NW-1:QW]} >= set_d.den);
    end
  end

  // Stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[4:0], valid_i};
    end
  end

  // Stage payload registers
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      el1_q  <= el_in;
      pl_q   <= pl_d;
      pr_q   <= pr_d;
      for (int i = 0; i < 3; i++) begin
        n2_q[i] <= el1_q[i];
        n3_q[i] <= n2_q[i];
      end
      cof3_q <= cof_d;
      dp_q   <= dp_d;
      cof4_q <= cof3_q;
      det_q  <= det_d;
      cof5_q <= cof4_q;
      set_q  <= set_d;
    end
  end

  assign valid_o = v_q[5];
  assign data_o  = set_q;

endmodule

// ----- rtl/mi3_divider.sv -----
// ----------------------------------------------------------------------------
// mi3_divider
// Restoring divider, one quotient bit per stage, nine lanes per stage.
// ----------------------------------------------------------------------------
module mi3_divider import mi3_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     en_i,
  input  logic     valid_i,
  input  mi3_div_t data_i,
  output logic     valid_o,
  output mi3_div_t data_o
);

  logic [QW-1:0] v_q;
  mi3_div_t      st_d [QW];
  mi3_div_t      st_q [QW];

  for (genvar s = 0; s < QW; s++) begin : g_step
    mi3_div_t src;
    if (s == 0) begin : g_first
      assign src = data_i;
    end else begin : g_next
      assign src = st_q[s-1];
    end

    // Shift in the next dividend bit, subtract when it fits
    always_comb begin
      logic [EW:0] t;
      logic        take;
      st_d[s] = src;
      for (int k = 0; k < NumElem; k++) begin
        t    = {src.lane[k].rem, src.lane[k].low[QW-1]};
        take = (t >= {1'b0, src.den});
        st_d[s].lane[k].rem = take ? EW'(t - {1'b0, src.den}) : t[EW-1:0];
        st_d[s].lane[k].low = {src.lane[k].low[QW-2:0], 1'b0};
        st_d[s].lane[k].quo = {src.lane[k].quo[QW-2:0], take};
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        st_q[s] <= st_d[s];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[QW-2:0], valid_i};
    end
  end

  assign valid_o = v_q[QW-1];
  assign data_o  = st_q[QW-1];

endmodule

// ----- dv/tb_matrix3_inverse_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_matrix3_inverse_unit
// Streams 3x3 Q4.12 matrices through the inverse unit with random gaps and
// output stalls, and checks every result against a local adjugate predictor.
// ----------------------------------------------------------------------------
module tb_matrix3_inverse_unit;
  import mi3_pkg::*;

  logic     clk_i;
  logic     rst_ni;
  logic     in_valid_i;
  logic     in_ready_o;
  mi3_in_t  in_data_i;
  logic     out_valid_o;
  logic     out_ready_i;
  mi3_out_t out_data_o;

  mi3_in_t  pending_mats[$];
  mi3_out_t expected_invs[$];
  int       n_errors;
  bit       quiet_phase;
  bit       stim_done;

  matrix3_inverse_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  // 10 ns clock
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // One element of the inverse: cof * 2^28 / det, rounded, saturated
  function automatic logic [31:0] inv_word(longint cof, longint det, ref bit clip);
    longint unsigned num, den, q;
    bit neg;
    num = (cof < 0 ? -cof : cof);
    num = num << 28;
    den = (det < 0 ? -det : det);
    q = (2 * num + den) / (2 * den);
    neg = ((cof < 0) != (det < 0)) && (q != 0);
    if (neg) begin
      if (q > 64'h8000_0000) begin
        clip = 1'b1;
        return 32'h8000_0000;
      end
      return 32'(-q);
    end
    if (q > 64'h7FFF_FFFF) begin
      clip = 1'b1;
      return 32'h7FFF_FFFF;
    end
    return q[31:0];
  endfunction

  function automatic mi3_out_t predict_inverse(mi3_in_t m);
    longint el [9];
    longint cof [9];
    logic [31:0] w [9];
    longint det;
    bit clip;
    mi3_out_t r;
    el = '{m.in_e0, m.in_e1, m.in_e2, m.in_e3, m.in_e4, m.in_e5, m.in_e6,
           m.in_e7, m.in_e8};
    // adjugate entries, column-major
    cof[0] = el[8] * el[4] - el[5] * el[7];
    cof[1] = el[2] * el[7] - el[8] * el[1];
    cof[2] = el[5] * el[1] - el[2] * el[4];
    cof[3] = el[5] * el[6] - el[8] * el[3];
    cof[4] = el[8] * el[0] - el[2] * el[6];
    cof[5] = el[2] * el[3] - el[5] * el[0];
    cof[6] = el[7] * el[3] - el[4] * el[6];
    cof[7] = el[1] * el[6] - el[7] * el[0];
    cof[8] = el[4] * el[0] - el[1] * el[3];
    det = el[0] * cof[0] + el[1] * cof[3] + el[2] * cof[6];
    r = '0;
    if (det == 0) begin
      r.singular = 1'b1;
      return r;
    end
    clip = 1'b0;
    for (int k = 0; k < 9; k++) w[k] = inv_word(cof[k], det, clip);
    r.out_e0 = w[0]; r.out_e1 = w[1]; r.out_e2 = w[2];
    r.out_e3 = w[3]; r.out_e4 = w[4]; r.out_e5 = w[5];
    r.out_e6 = w[6]; r.out_e7 = w[7]; r.out_e8 = w[8];
    r.saturated = clip;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH %s: got %h want %h at %0t", what, got, want, $realtime);
    n_errors++;
  endtask

  function automatic mi3_in_t mat_of(logic [15:0] a, logic [15:0] b, logic [15:0] c,
                                     logic [15:0] d, logic [15:0] e, logic [15:0] f,
                                     logic [15:0] g, logic [15:0] h, logic [15:0] i);
    return {a, b, c, d, e, f, g, h, i};
  endfunction

  function automatic logic [15:0] rand_elem(int style);
    case (style)
      0: return 16'($urandom);
      1: return 16'($signed($urandom_range(0, 16383)) - 8192);
      2: return 16'($signed($urandom_range(0, 255)) - 128);
      default: begin
        case ($urandom_range(0, 4))
          0: return 16'h8000;
          1: return 16'h7FFF;
          2: return 16'h0000;
          3: return 16'h1000;
          default: return 16'hF000;
        endcase
      end
    endcase
  endfunction

  // Stimulus: directed corner matrices, then random ones
  initial begin
    mi3_in_t m;
    int style;
    logic [15:0] one, neg_one, mx, mn;
    one = 16'h1000; neg_one = 16'hF000; mx = 16'h7FFF; mn = 16'h8000;
    n_errors = 0;
    stim_done = 1'b0;
    pending_mats.push_back(mat_of(one, 0, 0, 0, one, 0, 0, 0, one));
    pending_mats.push_back(mat_of(neg_one, 0, 0, 0, neg_one, 0, 0, 0, neg_one));
    pending_mats.push_back('0);
    pending_mats.push_back(mat_of(one, one, one, one, one, one, one, one, one));
    pending_mats.push_back(mat_of(mx, 0, 0, 0, mx, 0, 0, 0, mx));
    pending_mats.push_back(mat_of(mn, 0, 0, 0, mn, 0, 0, 0, mn));
    pending_mats.push_back(mat_of(16'h0001, 0, 0, 0, 16'h0001, 0, 0, 0, 16'h0001));
    pending_mats.push_back(mat_of(16'hFFFF, 0, 0, 0, 16'h0001, 0, 0, 0, 16'h0001));
    pending_mats.push_back(mat_of(mx, mn, mx, mn, mx, mn, mx, mn, mx));
    pending_mats.push_back(mat_of(mn, mn, mn, mn, mn, mn, mn, mn, mn));
    pending_mats.push_back(mat_of(0, one, 0, one, 0, 0, 0, 0, one));
    pending_mats.push_back(mat_of(16'h2000, 0, 0, 0, 16'h0800, 0, 0, 0, 16'h0400));
    pending_mats.push_back(mat_of(one, 16'h2000, 16'h3000, 16'h4000, 16'h5000, 16'h6000,
                                  16'h7000, 16'h7FFF, 16'h1234));
    pending_mats.push_back(mat_of(mx, mx, 0, mx, 16'h7FFE, 0, 0, 0, 16'h0001));
    pending_mats.push_back(mat_of(16'h0003, 0, 0, 0, one, 0, 0, 0, one));
    pending_mats.push_back(mat_of(16'hFFFD, 0, 0, 0, one, 0, 0, 0, one));
    for (int n = 0; n < 400; n++) begin
      style = $urandom_range(0, 9);
      style = (style < 4) ? 0 : (style < 7) ? 1 : (style < 9) ? 2 : 3;
      m = mat_of(rand_elem(style), rand_elem(style), rand_elem(style),
                 rand_elem(style), rand_elem(style), rand_elem(style),
                 rand_elem(style), rand_elem(style), rand_elem(style));
      // occasionally make a row a copy of another to force singular matrices
      if ($urandom_range(0, 9) == 0) begin
        m.in_e1 = m.in_e0; m.in_e4 = m.in_e3; m.in_e7 = m.in_e6;
      end
      pending_mats.push_back(m);
    end
    stim_done = 1'b1;
  end

  // Reset, then a phase without input gaps or output stalls
  initial begin
    rst_ni = 1'b0;
    quiet_phase = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (300) @(posedge clk_i);
    quiet_phase = 1'b1;
    repeat (200) @(posedge clk_i);
    quiet_phase = 1'b0;
  end

  // Request driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i  <= '0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        expected_invs.push_back(predict_inverse(in_data_i));
      end
      if (!in_valid_i || in_ready_o) begin
        if (pending_mats.size() > 0 && (quiet_phase || $urandom_range(0, 99) >= 34)) begin
          in_valid_i <= 1'b1;
          in_data_i  <= pending_mats.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Result monitor and output stalls
  always @(posedge clk_i or negedge rst_ni) begin
    mi3_out_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= quiet_phase || ($urandom_range(0, 99) >= 34);
      if (out_valid_o && out_ready_i) begin
        if (expected_invs.size() == 0) begin
          report_mismatch("unexpected result", 0, 0);
        end else begin
          want = expected_invs.pop_front();
          if (out_data_o.out_e0 !== want.out_e0)
            report_mismatch("out_e0", out_data_o.out_e0, want.out_e0);
          if (out_data_o.out_e1 !== want.out_e1)
            report_mismatch("out_e1", out_data_o.out_e1, want.out_e1);
          if (out_data_o.out_e2 !== want.out_e2)
            report_mismatch("out_e2", out_data_o.out_e2, want.out_e2);
          if (out_data_o.out_e3 !== want.out_e3)
            report_mismatch("out_e3", out_data_o.out_e3, want.out_e3);
          if (out_data_o.out_e4 !== want.out_e4)
            report_mismatch("out_e4", out_data_o.out_e4, want.out_e4);
          if (out_data_o.out_e5 !== want.out_e5)
            report_mismatch("out_e5", out_data_o.out_e5, want.out_e5);
          if (out_data_o.out_e6 !== want.out_e6)
            report_mismatch("out_e6", out_data_o.out_e6, want.out_e6);
          if (out_data_o.out_e7 !== want.out_e7)
            report_mismatch("out_e7", out_data_o.out_e7, want.out_e7);
          if (out_data_o.out_e8 !== want.out_e8)
            report_mismatch("out_e8", out_data_o.out_e8, want.out_e8);
          if (out_data_o.singular !== want.singular)
            report_mismatch("singular", out_data_o.singular, want.singular);
          if (out_data_o.saturated !== want.saturated)
            report_mismatch("saturated", out_data_o.saturated, want.saturated);
        end
      end
    end
  end

  // End of run: all requests accepted and all results back
  initial begin
    @(posedge rst_ni);
    wait (stim_done);
    while (pending_mats.size() > 0 || in_valid_i || expected_invs.size() > 0)
      @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    if (n_errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
